>>> rtl/rgblab_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rgblab_pkg
// Shared widths, matrix coefficients and fixed-point constants of the
// RGB to L*a*b* converter.
// ----------------------------------------------------------------------------
package rgblab_pkg;

  localparam int unsigned CH_W       = 16;
  localparam int unsigned SUM_W      = 33;
  localparam int unsigned NUM_W      = SUM_W + 1;
  localparam int unsigned DIV_BITS   = NUM_W;
  localparam int unsigned T_W        = 32;
  localparam int unsigned CBRT_STEPS = 22;
  localparam int unsigned F_W        = CBRT_STEPS;
  localparam int unsigned Y2_W       = 2 * CBRT_STEPS;
  // num register + divider bits + cube root load + cube root steps
  localparam int unsigned LANE_LAT   = 1 + DIV_BITS + 1 + CBRT_STEPS;

  // Q0.16 matrix coefficients
  localparam logic [15:0] C_XR = 16'd27031;
  localparam logic [15:0] C_XG = 16'd23434;
  localparam logic [15:0] C_XB = 16'd11824;
  localparam logic [15:0] C_YR = 16'd13938;
  localparam logic [15:0] C_YG = 16'd46869;
  localparam logic [15:0] C_YB = 16'd4730;
  localparam logic [15:0] C_ZR = 16'd1267;
  localparam logic [15:0] C_ZG = 16'd7811;
  localparam logic [15:0] C_ZB = 16'd62274;

  localparam logic [T_W-1:0] THRESH_Q16 = 32'd561;
  localparam logic [18:0]    LIN_SLOPE  = 19'd510329;
  localparam logic [14:0]    LIN_OFFSET = 15'd9039;
  localparam logic [17:0]    L_LIN_K    = 18'd231245;
  localparam logic [6:0]     L_HI_K     = 7'd116;

  localparam logic [15:0] WHITE_X_RST = 16'd19466;
  localparam logic [15:0] WHITE_Y_RST = 16'd20480;
  localparam logic [15:0] WHITE_Z_RST = 16'd22303;

  typedef enum logic [1:0] {
    REG_WHITE_X = 2'd0,
    REG_WHITE_Y = 2'd1,
    REG_WHITE_Z = 2'd2
  } reg_idx_e;

endpackage

>>> rtl/rgblab_lane.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rgblab_lane
// One color lane: rounded ratio sum/white (one quotient bit per stage),
// then f(t) as a pipelined integer cube root or the linear segment.
// ----------------------------------------------------------------------------
module rgblab_lane import rgblab_pkg::*; (
  input  logic             clk_i,
  input  logic             en_i,
  input  logic [SUM_W-1:0] sum_i,
  input  logic [15:0]      white_i,
  output logic [F_W-1:0]   f_o,
  output logic [T_W-1:0]   t_o
);

  logic [15:0]      weff;
  logic [NUM_W-1:0] dn_q  [DIV_BITS+1];
  logic [15:0]      rem_q [DIV_BITS+1];
  logic [NUM_W-1:0] quo;
  logic [T_W-1:0]   t_div;

  logic [63:0]      cx_q  [CBRT_STEPS+1];
  logic [F_W-1:0]   cy_q  [CBRT_STEPS+1];
  logic [Y2_W-1:0]  cy2_q [CBRT_STEPS+1];
  logic [T_W-1:0]   ct_q  [CBRT_STEPS+1];

  logic [F_W-1:0]   yf;
  logic [T_W-1:0]   tf;
  logic             above;
  logic [29:0]      lin_p;
  logic [14:0]      lin_f;

  // a zero white reads as one
  assign weff = (white_i == '0) ? 16'd1 : white_i;

  // round half up: add w/2 before the divide
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      dn_q[0]  <= NUM_W'(sum_i) + NUM_W'(weff[15:1]);
      rem_q[0] <= '0;
    end
  end

  for (genvar k = 0; k < DIV_BITS; k++) begin : g_div
    logic [16:0] trial;
    logic        ge;
    assign trial = {rem_q[k], dn_q[k][NUM_W-1]};
    assign ge    = trial >= {1'b0, weff};
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[k+1] <= ge ? 16'(trial - {1'b0, weff}) : trial[15:0];
        dn_q[k+1]  <= {dn_q[k][NUM_W-2:0], ge};
      end
    end
  end

  assign quo   = dn_q[DIV_BITS];
  assign t_div = (|quo[NUM_W-1:T_W]) ? '1 : quo[T_W-1:0];

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      cx_q[0]  <= {t_div, 32'b0};
      cy_q[0]  <= '0;
      cy2_q[0] <= '0;
      ct_q[0]  <= t_div;
    end
  end

  // digit-by-digit cube root, y^2 tracked alongside to avoid a multiplier
  for (genvar k = 0; k < CBRT_STEPS; k++) begin : g_cbrt
    localparam int unsigned SH = 3 * (CBRT_STEPS - 1 - k);
    logic [63:0] yd;
    logic [63:0] y2d;
    logic [63:0] bv;
    logic        ge;
    assign yd  = 64'(cy_q[k]) << 1;
    assign y2d = 64'(cy2_q[k]) << 2;
    assign bv  = (y2d << 1) + y2d + (yd << 1) + yd + 64'd1;
    assign ge  = (cx_q[k] >> SH) >= bv;
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        cx_q[k+1]  <= ge ? cx_q[k] - (bv << SH) : cx_q[k];
        cy_q[k+1]  <= F_W'(yd + 64'(ge));
        cy2_q[k+1] <= Y2_W'(ge ? y2d + (yd << 1) + 64'd1 : y2d);
        ct_q[k+1]  <= ct_q[k];
      end
    end
  end

  assign yf    = cy_q[CBRT_STEPS];
  assign tf    = ct_q[CBRT_STEPS];
  assign above = tf > THRESH_Q16;
  // linear branch only used for t at or below the threshold, which fits 10 bits
  assign lin_p = 30'(LIN_SLOPE) * 30'(tf[9:0]) + 30'd32768;
  assign lin_f = 15'(lin_p[29:16]) + LIN_OFFSET;

  assign f_o = above ? yf : F_W'(lin_f);
  assign t_o = tf;

endmodule

>>> rtl/rgb_to_lab_converter_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rgb_to_lab_converter_unit
// Per-pixel RGB (Q8.8) to CIE L*a*b* conversion with programmable white.
// ----------------------------------------------------------------------------
// Usage:
//   Input beats (red/green/blue/last_pixel) are taken when in_valid_i is high
//   and in_stall_o is low; result beats leave on out_valid_o / out_stall_i.
//   One pixel per clock is accepted while the output is not stalled. From input
//   beat to result beat the pipe has 3 matrix stages, 35 divider stages (rounding
//   add, then one quotient bit each), 23 cube-root stages (load, then one
//   root bit each) and 3 stages for L, a, b and saturation.
//   The whole pipe advances together: while the output holds a beat that
//   is stalled, every stage holds and in_stall_o is high; no beat is lost.
//   Reset clears all valid bits and loads the default reference white.
//   White registers sit on the APB port at 0x0, 0x4, 0x8 (Q8.8, 16 bits);
//   write them only while the pipe is empty. pready is always high.
// ----------------------------------------------------------------------------
module rgb_to_lab_converter_unit import rgblab_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [15:0] red_i,
  input  logic [15:0] green_i,
  input  logic [15:0] blue_i,
  input  logic        last_pixel_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [14:0] lightness_o,
  output logic signed [15:0] green_red_axis_o,
  output logic signed [15:0] blue_yellow_axis_o,
  output logic        last_out_o
);

  localparam int unsigned PIPE_LAT = 3 + LANE_LAT + 3;

  function automatic logic [15:0] sat_s16(input logic signed [20:0] v);
    logic [15:0] r;
    if (v > 21'sd32767)       r = 16'h7fff;
    else if (v < -21'sd32768) r = 16'h8000;
    else                      r = v[15:0];
    return r;
  endfunction

  logic [15:0] wx_q, wy_q, wz_q;
  logic        wr_en;

  logic                en;
  logic [PIPE_LAT-1:0] vld_q;
  logic [PIPE_LAT-1:0] lst_q;

  logic [15:0] r_q, g_q, b_q;
  logic [31:0] pxr_q, pxg_q, pxb_q, pyr_q, pyg_q, pyb_q, pzr_q, pzg_q, pzb_q;
  logic [SUM_W-1:0] sx_q, sy_q, sz_q;

  logic [F_W-1:0] fx, fy, fz;
  logic [T_W-1:0] ty;

  logic [F_W-1:0] fx_q, fy_q, fz_q;
  logic [9:0]     ty_lo_q;
  logic           abv3_q, abv4_q;

  logic signed [22:0] dfa, dfb;
  logic [28:0]        lhi_q;
  logic [27:0]        llo_q;
  logic signed [31:0] da_q, db_q;

  logic [29:0]        lsum;
  logic signed [23:0] lv;
  logic [28:0]        llsum;
  logic [14:0]        l_hi, l_lo;
  logic signed [32:0] asum, bsum;
  logic signed [20:0] aq, bq;

  logic [14:0]        lightness_q;
  logic [15:0]        gra_q, bya_q;

  // ---------------- configuration ----------------
  assign pready = 1'b1;
  assign wr_en  = psel & penable & pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wx_q <= WHITE_X_RST;
      wy_q <= WHITE_Y_RST;
      wz_q <= WHITE_Z_RST;
    end else if (wr_en) begin
      case (paddr[3:2])
        REG_WHITE_X: wx_q <= pwdata[15:0];
        REG_WHITE_Y: wy_q <= pwdata[15:0];
        REG_WHITE_Z: wz_q <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[3:2])
      REG_WHITE_X: prdata = {16'b0, wx_q};
      REG_WHITE_Y: prdata = {16'b0, wy_q};
      REG_WHITE_Z: prdata = {16'b0, wz_q};
      default:     prdata = '0;
    endcase
  end

  // ---------------- flow control ----------------
  assign en          = !vld_q[PIPE_LAT-1] || !out_stall_i;
  assign in_stall_o  = !en;
  assign out_valid_o = vld_q[PIPE_LAT-1];
  assign last_out_o  = lst_q[PIPE_LAT-1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en) begin
      vld_q <= {vld_q[PIPE_LAT-2:0], in_valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) lst_q <= {lst_q[PIPE_LAT-2:0], last_pixel_i};
  end

  // ---------------- matrix ----------------
  always_ff @(posedge clk_i) begin
    if (en) begin
      r_q <= red_i;
      g_q <= green_i;
      b_q <= blue_i;

      pxr_q <= 32'(r_q) * 32'(C_XR);
      pxg_q <= 32'(g_q) * 32'(C_XG);
      pxb_q <= 32'(b_q) * 32'(C_XB);
      pyr_q <= 32'(r_q) * 32'(C_YR);
      pyg_q <= 32'(g_q) * 32'(C_YG);
      pyb_q <= 32'(b_q) * 32'(C_YB);
      pzr_q <= 32'(r_q) * 32'(C_ZR);
      pzg_q <= 32'(g_q) * 32'(C_ZG);
      pzb_q <= 32'(b_q) * 32'(C_ZB);

      sx_q <= SUM_W'(pxr_q) + SUM_W'(pxg_q) + SUM_W'(pxb_q);
      sy_q <= SUM_W'(pyr_q) + SUM_W'(pyg_q) + SUM_W'(pyb_q);
      sz_q <= SUM_W'(pzr_q) + SUM_W'(pzg_q) + SUM_W'(pzb_q);
    end
  end

  // ---------------- ratio and f(t) ----------------
  rgblab_lane u_lane_x (
    .clk_i   (clk_i),
    .en_i    (en),
    .sum_i   (sx_q),
    .white_i (wx_q),
    .f_o     (fx),
    .t_o     ()
  );

  rgblab_lane u_lane_y (
    .clk_i   (clk_i),
    .en_i    (en),
    .sum_i   (sy_q),
    .white_i (wy_q),
    .f_o     (fy),
    .t_o     (ty)
  );

  rgblab_lane u_lane_z (
    .clk_i   (clk_i),
    .en_i    (en),
    .sum_i   (sz_q),
    .white_i (wz_q),
    .f_o     (fz),
    .t_o     ()
  );

  // ---------------- L, a, b ----------------
  assign dfa = $signed({1'b0, fx_q}) - $signed({1'b0, fy_q});
  assign dfb = $signed({1'b0, fy_q}) - $signed({1'b0, fz_q});

  always_ff @(posedge clk_i) begin
    if (en) begin
      fx_q    <= fx;
      fy_q    <= fy;
      fz_q    <= fz;
      ty_lo_q <= ty[9:0];
      abv3_q  <= ty > THRESH_Q16;

      lhi_q  <= 29'(fy_q) * 29'(L_HI_K);
      llo_q  <= 28'(ty_lo_q) * 28'(L_LIN_K);
      da_q   <= 32'(dfa) * 32'sd500;
      db_q   <= 32'(dfb) * 32'sd200;
      abv4_q <= abv3_q;
    end
  end

  assign lsum  = 30'(lhi_q) + 30'd128;
  assign lv    = $signed({2'b0, lsum[29:8]}) - 24'sd4096;
  assign l_hi  = (lv < 0) ? 15'd0 : (lv > 24'sd32767) ? 15'h7fff : lv[14:0];
  assign llsum = 29'(llo_q) + 29'd32768;
  assign l_lo  = 15'(llsum[28:16]);

  // round half up, then floor divide by 4096
  assign asum = 33'(da_q) + 33'sd2048;
  assign bsum = 33'(db_q) + 33'sd2048;
  assign aq   = 21'(asum >>> 12);
  assign bq   = 21'(bsum >>> 12);

  always_ff @(posedge clk_i) begin
    if (en) begin
      lightness_q <= abv4_q ? l_hi : l_lo;
      gra_q       <= sat_s16(aq);
      bya_q       <= sat_s16(bq);
    end
  end

  assign lightness_o        = lightness_q;
  assign green_red_axis_o   = gra_q;
  assign blue_yellow_axis_o = bya_q;

endmodule

>>> rtl/rgblab_chk.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rgblab_chk
// Port-level checks of the converter's flow control, bound to the top level.
// ----------------------------------------------------------------------------
module rgblab_chk (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid_i,
  input logic        in_stall_o,
  input logic        out_valid_o,
  input logic        out_stall_i,
  input logic [14:0] lightness_o,
  input logic [15:0] green_red_axis_o,
  input logic [15:0] blue_yellow_axis_o,
  input logic        last_out_o
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(lightness_o) &&
      $stable(green_red_axis_o) && $stable(blue_yellow_axis_o) && $stable(last_out_o))
    else $error("stalled result beat changed");

  // a stalled output freezes the whole pipe, so input must stall too
  a_stall_back: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |-> in_stall_o)
    else $error("input taken while output stalled");

  a_no_stall_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_o |-> !in_stall_o)
    else $error("input stalled with empty output");

  a_stall_source: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> out_valid_o && out_stall_i)
    else $error("input stall without output back-pressure");

endmodule

bind rgb_to_lab_converter_unit rgblab_chk u_rgblab_chk (.*);

>>> test/tb_rgb_to_lab_converter_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_rgb_to_lab_converter_unit
// Self-checking bench for the RGB to L*a*b* converter. Pixels go in over the
// valid/stall input port with random gaps, and results are taken with random
// stalls plus one long hold-off that backs up the whole pipe. Every result
// beat is compared field by field with a given value or a bit-exact model of the
// converter, under several reference-white settings written over APB between phases.
// ----------------------------------------------------------------------------
module tb_rgb_to_lab_converter_unit;
  import rgblab_pkg::*;

  localparam int PIPE_LAT  = 64;
  localparam int MAX_CYC   = 400000;
  localparam int N_RANDOM  = 1680;

  typedef struct packed {
    logic [15:0] red;
    logic [15:0] green;
    logic [15:0] blue;
    logic        last;
  } pixel_t;

  typedef struct packed {
    logic [14:0]        light;
    logic signed [15:0] ga;
    logic signed [15:0] by;
    logic               last;
  } lab_t;

  typedef struct {
    pixel_t pix;
    bit     has_lab;
    lab_t   lab;
  } vec_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [3:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic pready;
  logic in_valid_i = 1'b0;
  logic in_stall_o;
  logic [15:0] red_i = '0, green_i = '0, blue_i = '0;
  logic last_pixel_i = 1'b0;
  logic out_valid_o;
  logic out_stall_i = 1'b0;
  logic [14:0] lightness_o;
  logic signed [15:0] green_red_axis_o, blue_yellow_axis_o;
  logic last_out_o;

  rgb_to_lab_converter_unit dut (.*);

  always #5 clk_i = ~clk_i;

  // model copy of the white point
  logic [15:0] wp_x, wp_y, wp_z;

  lab_t lab_queue[$];
  int   errors = 0;
  int   n_beats = 0;
  int   n_lin = 0;
  int   cycles = 0;
  int   sink_wait = 0;
  bit   hold_off = 1'b0;
  bit   sink_on = 1'b0;

  function automatic longint unsigned cube_root(longint unsigned v);
    longint unsigned y, b;
    y = 0;
    for (int s = 63; s >= 0; s -= 3) begin
      y = y << 1;
      b = 3 * y * (y + 1) + 1;
      if ((v >> s) >= b) begin
        v = v - (b << s);
        y = y + 1;
      end
    end
    return y;
  endfunction

  function automatic longint unsigned white_ratio(longint unsigned sum, logic [15:0] w);
    longint unsigned d, t;
    d = (w == 0) ? 1 : w;
    t = (sum + d / 2) / d;
    if (t > 64'hFFFF_FFFF) t = 64'hFFFF_FFFF;
    return t;
  endfunction

  function automatic longint lab_curve(longint unsigned t);
    if (t > THRESH_Q16) return longint'(cube_root(t << 32));
    return longint'(((64'd510329 * t + 32768) >> 16) + 9039);
  endfunction

  function automatic logic [15:0] axis_sat(longint v);
    longint q;
    v = v + 2048;
    q = (v >= 0) ? v / 4096 : -((-v + 4095) / 4096);
    if (q > 32767) q = 32767;
    if (q < -32768) q = -32768;
    return q[15:0];
  endfunction

  function automatic lab_t convert_pixel(pixel_t p);
    longint unsigned sx, sy, sz, tx, ty, tz;
    longint fx, fy, fz, l;
    lab_t r;
    sx = 27031 * longint'(p.red) + 23434 * longint'(p.green) + 11824 * longint'(p.blue);
    sy = 13938 * longint'(p.red) + 46869 * longint'(p.green) + 4730 * longint'(p.blue);
    sz = 1267 * longint'(p.red) + 7811 * longint'(p.green) + 62274 * longint'(p.blue);
    tx = white_ratio(sx, wp_x);
    ty = white_ratio(sy, wp_y);
    tz = white_ratio(sz, wp_z);
    fx = lab_curve(tx);
    fy = lab_curve(ty);
    fz = lab_curve(tz);
    if (ty > THRESH_Q16) l = ((116 * fy + 128) / 256) - 4096;
    else l = longint'((64'd231245 * ty + 32768) >> 16);
    if (l < 0) l = 0;
    if (l > 32767) l = 32767;
    r.light = l[14:0];
    r.ga = axis_sat(500 * (fx - fy));
    r.by = axis_sat(200 * (fy - fz));
    r.last = p.last;
    return r;
  endfunction

  task automatic apb_write(reg_idx_e idx, logic [15:0] val);
    @(posedge clk_i);
    psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
    paddr <= 4'(idx) << 2; pwdata <= {16'h0, val};
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    case (idx)
      REG_WHITE_X: wp_x = val;
      REG_WHITE_Y: wp_y = val;
      default:     wp_z = val;
    endcase
  endtask

  task automatic set_white(logic [15:0] x, logic [15:0] y, logic [15:0] z);
    apb_write(REG_WHITE_X, x);
    apb_write(REG_WHITE_Y, y);
    apb_write(REG_WHITE_Z, z);
  endtask

  // valid stays up across back-to-back beats; it drops only for a gap
  task automatic send_pixel(pixel_t p, bit has_lab, lab_t lab);
    int gap;
    gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 18);
    if ($urandom_range(0, 1)) gap = 0;
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    {red_i, green_i, blue_i, last_pixel_i} <= p;
    lab_queue.push_back(has_lab ? lab : convert_pixel(p));
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
  endtask

  task automatic drain;
    in_valid_i <= 1'b0;
    while (lab_queue.size() != 0) @(posedge clk_i);
    repeat (PIPE_LAT + 4) @(posedge clk_i);
  endtask

  function automatic pixel_t rand_pixel();
    pixel_t p;
    case ($urandom_range(0, 3))
      0: p = {16'($urandom_range(0, 64)), 16'($urandom_range(0, 64)),
              16'($urandom_range(0, 64)), 1'b0};
      1: p = {16'($urandom_range(0, 16'h01FF)), 16'($urandom_range(0, 16'h01FF)),
              16'($urandom_range(0, 16'h01FF)), 1'b0};
      default: p = {16'($urandom), 16'($urandom), 16'($urandom), 1'b0};
    endcase
    p.last = ($urandom_range(0, 15) == 0);
    return p;
  endfunction

  // receiver: random wait after each beat, plus forced hold-off
  always @(posedge clk_i) begin
    if (sink_on) begin
      if (out_valid_o && !out_stall_i)
        sink_wait = ($urandom_range(0, 1) == 0) ? 0 : $urandom_range(0, 18);
      if (hold_off) begin
        out_stall_i <= 1'b1;
      end else if (sink_wait > 0) begin
        sink_wait--;
        out_stall_i <= 1'b1;
      end else begin
        out_stall_i <= 1'b0;
      end
    end
  end

  always @(posedge clk_i) begin
    lab_t got, exp_lab;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      got = {lightness_o, green_red_axis_o, blue_yellow_axis_o, last_out_o};
      if (lab_queue.size() == 0) begin
        $display("%0t: unexpected beat, expected none, actual %h", $time, got);
        errors++;
      end else begin
        exp_lab = lab_queue.pop_front();
        n_beats++;
        if (got.light !== exp_lab.light) begin
          $display("%0t: lightness expected %0d actual %0d", $time, exp_lab.light, got.light);
          errors++;
        end
        if (got.ga !== exp_lab.ga) begin
          $display("%0t: a expected %0d actual %0d", $time, exp_lab.ga, got.ga);
          errors++;
        end
        if (got.by !== exp_lab.by) begin
          $display("%0t: b expected %0d actual %0d", $time, exp_lab.by, got.by);
          errors++;
        end
        if (got.last !== exp_lab.last) begin
          $display("%0t: last expected %0b actual %0b", $time, exp_lab.last, got.last);
          errors++;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    cycles++;
    if (cycles > MAX_CYC) begin
      $display("rgb_to_lab_converter_unit test failed");
      $finish;
    end
  end

  // long hold-off so the pipe fills and backs up the input
  initial begin
    wait (n_beats > 300);
    @(posedge clk_i);
    hold_off = 1'b1;
    repeat (150) @(posedge clk_i);
    hold_off = 1'b0;
  end

  vec_t vectors[$];
  lab_t zero_lab;

  initial begin
    pixel_t p;
    logic [15:0] wset[5][3];
    wp_x = WHITE_X_RST; wp_y = WHITE_Y_RST; wp_z = WHITE_Z_RST;
    zero_lab = '0;
    // black with default white: L, a, b all zero
    vectors.push_back('{'{16'h0000, 16'h0000, 16'h0000, 1'b0}, 1'b1, zero_lab});
    vectors.push_back('{'{16'h0000, 16'h0000, 16'h0000, 1'b1}, 1'b1, '{15'd0, 16'sd0, 16'sd0, 1'b1}});
    vectors.push_back('{'{16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b0}, 1'b0, zero_lab});
    vectors.push_back('{'{16'hFFFF, 16'h0000, 16'h0000, 1'b1}, 1'b0, zero_lab});
    vectors.push_back('{'{16'h0000, 16'hFFFF, 16'h0000, 1'b0}, 1'b0, zero_lab});
    vectors.push_back('{'{16'h0000, 16'h0000, 16'hFFFF, 1'b0}, 1'b0, zero_lab});
    vectors.push_back('{'{16'h0100, 16'h0100, 16'h0100, 1'b0}, 1'b0, zero_lab});
    vectors.push_back('{'{16'h0001, 16'h0001, 16'h0001, 1'b0}, 1'b0, zero_lab});
    vectors.push_back('{'{16'h0008, 16'h0008, 16'h0008, 1'b0}, 1'b0, zero_lab});
    vectors.push_back('{'{16'h0009, 16'h0009, 16'h0009, 1'b1}, 1'b0, zero_lab});
    vectors.push_back('{'{16'h5555, 16'hAAAA, 16'h5555, 1'b0}, 1'b0, zero_lab});
    vectors.push_back('{'{16'hAAAA, 16'h5555, 16'hAAAA, 1'b1}, 1'b0, zero_lab});

    // white settings: reset, minimum (ratio overflow), zero, maximum, mixed
    wset[0] = '{WHITE_X_RST, WHITE_Y_RST, WHITE_Z_RST};
    wset[1] = '{16'd1, 16'd1, 16'd1};
    wset[2] = '{16'd0, 16'd0, 16'd0};
    wset[3] = '{16'hFFFF, 16'hFFFF, 16'hFFFF};
    wset[4] = '{16'h0100, 16'hFFFF, 16'd1};

    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    sink_on = 1'b1;

    foreach (vectors[i]) send_pixel(vectors[i].pix, vectors[i].has_lab, vectors[i].lab);
    drain();

    for (int ph = 1; ph < 5; ph++) begin
      set_white(wset[ph][0], wset[ph][1], wset[ph][2]);
      foreach (vectors[i]) send_pixel(vectors[i].pix, 1'b0, zero_lab);
      repeat (40) send_pixel(rand_pixel(), 1'b0, zero_lab);
      drain();
    end

    for (int ph = 0; ph < 4; ph++) begin
      if (ph == 3) set_white(WHITE_X_RST, WHITE_Y_RST, WHITE_Z_RST);
      else set_white(16'($urandom_range(1, 16'hFFFF)), 16'($urandom_range(1, 16'hFFFF)),
                     16'($urandom_range(1, 16'hFFFF)));
      for (int k = 0; k < N_RANDOM / 4; k++) begin
        p = rand_pixel();
        if (p.green < 16'h0200) n_lin++;
        send_pixel(p, 1'b0, zero_lab);
      end
      drain();
    end

    $display("Checked %0d result beats across 9 white-point settings,", n_beats);
    $display("%0d random pixels in the dark range, plus one long output hold-off.", n_lin);
    if (errors == 0) $display("rgb_to_lab_converter_unit test passed");
    else $display("rgb_to_lab_converter_unit test failed");
    $finish;
  end

endmodule
